// ===== sv/rscn_pkg.sv =====
// Package for the running-statistics channel normaliser.
// Holds the shared types, codes and fixed widths; it depends on nothing else.
`default_nettype none
package rscn_pkg;

    // Fixed field widths
    localparam int CH_W     = 6;
    localparam int NUM_IDS  = 64;
    localparam int X_W      = 16;
    localparam int CC_W     = 7;
    localparam int SPC_W    = 16;
    localparam int EPS_W    = 24;
    localparam int ILT_W    = 16;
    localparam int ALPHA_W  = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 24;

    // Stored word widths
    localparam int MEAN_W = 32;
    localparam int VAR_W  = 40;
    localparam int INV_W  = 32;
    localparam int BSUM_W = 41;
    localparam int BSQ_W  = 48;
    localparam int LC_W   = 16;

    // Iterative unit widths
    localparam int ITER_NW = 71;
    localparam int ITER_DW = 41;

    localparam logic [VAR_W-1:0]   VAR_RST   = 40'h00_0100_0000;
    localparam logic [INV_W-1:0]   INV_RST   = 32'h0080_0000;
    localparam logic [VAR_W-1:0]   VAR_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [EPS_W-1:0]   EPS_FLOOR = 24'd168;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h1_0000;
    localparam logic [LC_W-1:0]    LC_MAX    = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_CH_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd4;

    typedef enum logic [1:0] {
        ACT_NORM   = 2'd0,
        ACT_GRAD   = 2'd1,
        ACT_ACCUM  = 2'd2,
        ACT_COMMIT = 2'd3
    } action_t;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } iter_op_t;

    typedef struct packed {
        logic               start;
        iter_op_t           op;
        logic [ITER_NW-1:0] num;
        logic [ITER_DW-1:0] den;
    } iter_req_t;

    typedef struct packed {
        logic [INV_W-1:0]  inv;
        logic [VAR_W-1:0]  var_q;
        logic [MEAN_W-1:0] mean;
    } stat_entry_t;

    typedef struct packed {
        logic [BSQ_W-1:0]  bsq;
        logic [BSUM_W-1:0] bsum;
    } sum_entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ITEM_RD,
        ST_N_DIFF,
        ST_N_MUL,
        ST_N_RND,
        ST_A_UPD,
        ST_OUT,
        ST_C_START,
        ST_C_ADIV,
        ST_C_RD,
        ST_C_LOAD,
        ST_C_MBDIV,
        ST_C_MEAN1,
        ST_C_MEAN2,
        ST_C_MEAN3,
        ST_C_SQ1,
        ST_C_SQ2,
        ST_C_T1WAIT,
        ST_C_VAR1,
        ST_C_VAR2,
        ST_C_VAR3,
        ST_C_VAR4,
        ST_C_VAR5,
        ST_C_QWAIT,
        ST_C_SQWAIT,
        ST_C_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== sv/running_stat_channel_normalizer_top.sv =====
// Top level of the running-statistics channel normaliser.
// Depends on rscn_pkg, rscn_ram (statistics and batch sums) and rscn_iter.
`default_nettype none
//
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  tuser: action; tdata: channel, sample
//  m_        out        m_tvalid/m_tready  tuser: saturated, commit_done; tdata: value
//  cfg_      in         cfg_wr_en only     register index and write data
//
//  A normalize or gradient item passes through ST_ITEM_RD, ST_N_DIFF, ST_N_MUL,
//  ST_N_RND and ST_OUT, an accumulate item through ST_ITEM_RD and ST_A_UPD; for a
//  channel not in use the former goes straight to ST_OUT and the latter is dropped.
//  A commit walks the channels in use one at a time, paced by the single
//  bit-serial unit that does the two divisions, the inverse division and the
//  square root of every channel; early learning adds the alpha division to it.
//  Reset is synchronous and active low; memory contents are never cleared,
//  per-entry valid bits stand for the reset values instead. The result sits
//  in an output register, so a stalled m_ side holds back only the next result.
//
module running_stat_channel_normalizer_top #(
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // tdata: channel [5:0], sample [21:6], zero [23:22]
    input  wire logic [23:0]                      s_tdata,
    // tuser: action [1:0]
    input  wire logic [1:0]                       s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata: result_value [15:0]
    output logic [15:0]                           m_tdata,
    // tuser: saturated [0], commit_done [1]
    output logic [1:0]                            m_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_wr_en,
    input  wire logic [rscn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rscn_pkg::CFG_W-1:0]       cfg_wdata
);
    import rscn_pkg::*;

    // Channel ids are six bits wide, so no more than 64 entries can ever be
    // addressed, whatever the channel limit.
    localparam int DEPTH = (MAX_CHANNELS < NUM_IDS) ? MAX_CHANNELS : NUM_IDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration and learn counter
    logic [CC_W-1:0]    cc_reg;
    logic [SPC_W-1:0]   spc_reg;
    logic [EPS_W-1:0]   eps_reg;
    logic [ILT_W-1:0]   ilt_reg;
    logic [ALPHA_W-1:0] sal_reg;
    logic [LC_W-1:0]    lc_reg;

    state_t st_reg, st_next;

    // Item registers
    action_t               act_reg;
    logic [CH_W-1:0]       ch_reg;
    logic signed [X_W-1:0] x_reg;

    // Valid bits standing in for the reset values of the two memories
    logic [DEPTH-1:0] stat_vld_reg;
    logic [DEPTH-1:0] sum_vld_reg;

    // Normalise datapath
    logic [32:0]  nmag_reg;
    logic         neg_reg;
    logic [INV_W-1:0] inv_reg;
    logic [64:0]  prod_reg;
    logic [15:0]  res_val_reg;
    logic         res_sat_reg;
    logic         res_cd_reg;

    // Commit datapath
    logic [CC_W-1:0]           idx_reg;
    logic [ALPHA_W-1:0]        alpha_reg;
    logic signed [MEAN_W-1:0]  om_reg;
    logic [VAR_W-1:0]          ov_reg;
    logic [BSQ_W-1:0]          bq_reg;
    logic signed [MEAN_W-1:0]  mb_reg;
    logic signed [32:0]        d1_reg;
    logic [49:0]               p1_reg;
    logic                      n1_reg;
    logic signed [MEAN_W-1:0]  m_reg;
    logic [39:0]               mb2_reg;
    logic [41:0]               dd_reg;
    logic [55:0]               t1_reg;
    logic [VAR_W-1:0]          vb_reg;
    logic signed [40:0]        dv_reg;
    logic [56:0]               p2_reg;
    logic                      n2_reg;
    logic [VAR_W-1:0]          v_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    // Memory ports
    logic          rd_en;
    logic [AW-1:0] cur_addr;
    logic          stat_we;
    stat_entry_t   stat_wd, stat_q;
    logic          sum_we;
    sum_entry_t    sum_wd, sum_q;
    logic [$bits(stat_entry_t)-1:0] stat_rd_raw;
    logic [$bits(sum_entry_t)-1:0]  sum_rd_raw;

    iter_req_t          iter_req;
    logic               iter_busy;
    logic [ITER_NW-1:0] iter_res;

    // Common combinational values
    action_t            in_act;
    logic [CH_W-1:0]    in_ch;
    logic [X_W-1:0]     in_x;
    logic [CC_W-1:0]    lim;
    logic               in_ok;
    logic               out_free;
    logic [SPC_W-1:0]   nden;
    logic [EPS_W-1:0]   eff_eps;
    logic [LC_W-1:0]    lc_new;
    logic [16:0]        lc1;
    logic               early;

    logic signed [MEAN_W-1:0] mean_e;
    logic [VAR_W-1:0]         var_e;
    logic [INV_W-1:0]         inv_e;
    logic signed [BSUM_W-1:0] bsum_e;
    logic [BSQ_W-1:0]         bsq_e;

    assign in_act   = action_t'(s_tuser);
    assign in_ch    = s_tdata[CH_W-1:0];
    assign in_x     = s_tdata[CH_W+X_W-1:CH_W];
    assign lim      = (cc_reg < CC_W'(DEPTH)) ? cc_reg : CC_W'(DEPTH);
    assign in_ok    = {1'b0, in_ch} < lim;
    assign out_free = !m_tvalid_reg || m_tready;
    assign nden     = (spc_reg == '0) ? SPC_W'(1) : spc_reg;
    assign eff_eps  = (eps_reg > EPS_FLOOR) ? eps_reg : EPS_FLOOR;
    assign lc_new   = (lc_reg < LC_MAX) ? lc_reg + LC_W'(1) : lc_reg;
    assign lc1      = {1'b0, lc_new} + 17'd1;
    assign early    = lc_new < ilt_reg;

    assign cur_addr = (act_reg == ACT_COMMIT) ? idx_reg[AW-1:0] : ch_reg[AW-1:0];
    assign stat_q   = stat_entry_t'(stat_rd_raw);
    assign sum_q    = sum_entry_t'(sum_rd_raw);

    // An entry that was never written reads as its reset value.
    assign mean_e = stat_vld_reg[cur_addr] ? $signed(stat_q.mean) : '0;
    assign var_e  = stat_vld_reg[cur_addr] ? stat_q.var_q : VAR_RST;
    assign inv_e  = stat_vld_reg[cur_addr] ? stat_q.inv : INV_RST;
    assign bsum_e = sum_vld_reg[cur_addr] ? $signed(sum_q.bsum) : '0;
    assign bsq_e  = sum_vld_reg[cur_addr] ? sum_q.bsq : '0;

    rscn_ram #(
        .WIDTH ($bits(stat_entry_t)),
        .DEPTH (DEPTH)
    ) u_stat_ram (
        .aclk    (aclk),
        .wr_en   (stat_we),
        .wr_addr (cur_addr),
        .wr_data (stat_wd),
        .rd_en   (rd_en),
        .rd_addr (cur_addr),
        .rd_data (stat_rd_raw)
    );

    rscn_ram #(
        .WIDTH ($bits(sum_entry_t)),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_we),
        .wr_addr (cur_addr),
        .wr_data (sum_wd),
        .rd_en   (rd_en),
        .rd_addr (cur_addr),
        .rd_data (sum_rd_raw)
    );

    rscn_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iter_req),
        .busy    (iter_busy),
        .result  (iter_res)
    );

    // Accumulate: add the sample and its square, each saturating.
    logic signed [BSUM_W:0] acc_s;
    logic signed [31:0]     acc_sq;
    logic [BSQ_W:0]         acc_q;
    always_comb begin
        acc_s  = BSUM_W'(bsum_e) + (BSUM_W+1)'(x_reg);
        acc_sq = x_reg * x_reg;
        acc_q  = {1'b0, bsq_e} + (BSQ_W+1)'(acc_sq[30:0]);
        if (acc_s > $signed(42'sh80_0000_0000)) begin
            sum_wd.bsum = 41'h080_0000_0000;
        end else if (acc_s < -$signed(42'sh80_0000_0000)) begin
            sum_wd.bsum = 41'h180_0000_0000;
        end else begin
            sum_wd.bsum = acc_s[BSUM_W-1:0];
        end
        sum_wd.bsq = acc_q[BSQ_W] ? {BSQ_W{1'b1}} : acc_q[BSQ_W-1:0];
    end

    // Sequencer: next state, memory and iterative-unit control.
    always_comb begin
        st_next       = st_reg;
        s_tready      = 1'b0;
        rd_en         = 1'b0;
        sum_we        = 1'b0;
        stat_we       = 1'b0;
        iter_req      = '0;
        iter_req.op   = OP_DIV;
        case (st_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_act == ACT_COMMIT) begin
                        st_next = ST_C_START;
                    end else if (in_ok) begin
                        st_next = ST_ITEM_RD;
                    end else if (in_act == ACT_ACCUM) begin
                        st_next = ST_IDLE;
                    end else begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_ITEM_RD: begin
                rd_en   = 1'b1;
                st_next = (act_reg == ACT_ACCUM) ? ST_A_UPD : ST_N_DIFF;
            end
            ST_N_DIFF: st_next = ST_N_MUL;
            ST_N_MUL:  st_next = ST_N_RND;
            ST_N_RND:  st_next = ST_OUT;
            ST_A_UPD: begin
                sum_we  = 1'b1;
                st_next = ST_IDLE;
            end
            ST_OUT: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            ST_C_START: begin
                if (early) begin
                    iter_req.start = 1'b1;
                    iter_req.num   = ITER_NW'(17'h1_0000 + {1'b0, lc1[16:1]});
                    iter_req.den   = ITER_DW'(lc1);
                    st_next        = ST_C_ADIV;
                end else begin
                    st_next = ST_C_RD;
                end
            end
            ST_C_ADIV: begin
                if (!iter_busy) begin
                    st_next = ST_C_RD;
                end
            end
            ST_C_RD: begin
                if (idx_reg >= lim) begin
                    st_next = ST_C_DONE;
                end else begin
                    rd_en   = 1'b1;
                    st_next = ST_C_LOAD;
                end
            end
            ST_C_LOAD: begin
                iter_req.start = 1'b1;
                iter_req.num   = ITER_NW'({(bsum_e[BSUM_W-1] ? 41'(-bsum_e) : 41'(bsum_e)),
                                           16'h0000}) + ITER_NW'(nden[SPC_W-1:1]);
                iter_req.den   = ITER_DW'(nden);
                st_next        = ST_C_MBDIV;
            end
            ST_C_MBDIV: begin
                if (!iter_busy) begin
                    st_next = ST_C_MEAN1;
                end
            end
            ST_C_MEAN1: begin
                iter_req.start = 1'b1;
                iter_req.num   = ITER_NW'({bq_reg, 8'h00}) + ITER_NW'(nden[SPC_W-1:1]);
                iter_req.den   = ITER_DW'(nden);
                st_next        = ST_C_MEAN2;
            end
            ST_C_MEAN2:  st_next = ST_C_MEAN3;
            ST_C_MEAN3:  st_next = ST_C_SQ1;
            ST_C_SQ1:    st_next = ST_C_SQ2;
            ST_C_SQ2:    st_next = ST_C_T1WAIT;
            ST_C_T1WAIT: begin
                if (!iter_busy) begin
                    st_next = ST_C_VAR1;
                end
            end
            ST_C_VAR1: st_next = ST_C_VAR2;
            ST_C_VAR2: st_next = ST_C_VAR3;
            ST_C_VAR3: st_next = ST_C_VAR4;
            ST_C_VAR4: st_next = ST_C_VAR5;
            ST_C_VAR5: begin
                iter_req.start = 1'b1;
                iter_req.num   = {1'b1, {(ITER_NW-1){1'b0}}};
                iter_req.den   = ITER_DW'({1'b0, v_reg}) + ITER_DW'(eff_eps);
                st_next        = ST_C_QWAIT;
            end
            ST_C_QWAIT: begin
                if (!iter_busy) begin
                    iter_req.start = 1'b1;
                    iter_req.op    = OP_SQRT;
                    iter_req.num   = ITER_NW'(iter_res[63:0]);
                    st_next        = ST_C_SQWAIT;
                end
            end
            ST_C_SQWAIT: begin
                if (!iter_busy) begin
                    stat_we = 1'b1;
                    st_next = ST_C_RD;
                end
            end
            ST_C_DONE: st_next = ST_OUT;
            default:   st_next = ST_IDLE;
        endcase
    end

    assign stat_wd.mean  = m_reg;
    assign stat_wd.var_q = v_reg;
    assign stat_wd.inv   = (|iter_res[63:32]) ? {INV_W{1'b1}} : iter_res[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // Control state: configuration, learn counter, valid bits, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg       <= CC_W'(1);
            spc_reg      <= SPC_W'(1);
            eps_reg      <= EPS_FLOOR;
            ilt_reg      <= '0;
            sal_reg      <= ALPHA_ONE;
            lc_reg       <= '0;
            stat_vld_reg <= '0;
            sum_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CH_COUNT: cc_reg  <= cfg_wdata[CC_W-1:0];
                    REG_SAMPLES:  spc_reg <= cfg_wdata[SPC_W-1:0];
                    REG_EPSILON:  eps_reg <= cfg_wdata[EPS_W-1:0];
                    REG_INIT_LT:  ilt_reg <= cfg_wdata[ILT_W-1:0];
                    REG_ALPHA:    sal_reg <= cfg_wdata[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (st_reg == ST_C_START) begin
                lc_reg <= lc_new;
            end
            if (sum_we) begin
                sum_vld_reg[cur_addr] <= 1'b1;
            end
            if (st_reg == ST_C_DONE) begin
                sum_vld_reg <= '0;
            end
            if (stat_we) begin
                stat_vld_reg[cur_addr] <= 1'b1;
            end
            if (st_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath combinational values
    logic signed [33:0] ndiff;
    logic [65:0]        rnd_sum;
    logic [27:0]        rnd_m;
    logic [31:0]        mbq_pos;
    logic               mbq_big;
    logic [50:0]        r1_sum;
    logic signed [36:0] mt;
    logic [31:0]        mbmag;
    logic [63:0]        mbsq;
    logic signed [32:0] dfin;
    logic [32:0]        dmag;
    logic [65:0]        dsq;
    logic signed [58:0] vt;
    logic [39:0]        dvmag;
    logic [57:0]        r2_sum;
    logic signed [43:0] vt2;

    always_comb begin
        ndiff   = $signed({x_reg, 16'h0000});
        ndiff   = ndiff - mean_e;
        if (act_reg == ACT_NORM) begin
            rnd_sum = 66'(prod_reg[64:1]) + 66'(64'h20_0000_0000) + 66'(prod_reg[0]);
            rnd_m   = 28'(rnd_sum >> 38);
        end else begin
            rnd_sum = 66'(prod_reg[64:1]) + 66'(64'h20_0000) + 66'(prod_reg[0]);
            rnd_m   = 28'(rnd_sum >> 22);
        end
        mbq_big = |iter_res[ITER_NW-1:31];
        mbq_pos = iter_res[31:0];
        r1_sum  = 51'(p1_reg) + 51'(16'h8000);
        mt      = om_reg;
        mt      = n1_reg ? mt - 37'(r1_sum[50:16]) : mt + 37'(r1_sum[50:16]);
        mbmag   = mb_reg[31] ? 32'(-mb_reg) : 32'(mb_reg);
        mbsq    = mbmag * mbmag;
        dfin    = mb_reg;
        dfin    = dfin - m_reg;
        dmag    = dfin[32] ? 33'(-dfin) : 33'(dfin);
        dsq     = dmag * dmag;
        vt      = 59'(t1_reg);
        vt      = vt - 59'(mb2_reg) + 59'(dd_reg);
        dvmag   = dv_reg[40] ? 40'(-dv_reg) : 40'(dv_reg);
        r2_sum  = 58'(p2_reg) + 58'(16'h8000);
        vt2     = 44'(ov_reg);
        vt2     = n2_reg ? vt2 - 44'(r2_sum[57:16]) : vt2 + 44'(r2_sum[57:16]);
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            ST_IDLE: begin
                act_reg     <= in_act;
                ch_reg      <= in_ch;
                x_reg       <= $signed(in_x);
                res_val_reg <= '0;
                res_sat_reg <= 1'b0;
                res_cd_reg  <= 1'b0;
            end
            ST_N_DIFF: begin
                inv_reg <= inv_e;
                if (act_reg == ACT_NORM) begin
                    neg_reg  <= ndiff[33];
                    nmag_reg <= ndiff[33] ? 33'(-ndiff) : 33'(ndiff);
                end else begin
                    neg_reg  <= x_reg[X_W-1];
                    nmag_reg <= x_reg[X_W-1] ? 33'(-x_reg) : 33'(x_reg);
                end
            end
            ST_N_MUL: prod_reg <= nmag_reg * inv_reg;
            ST_N_RND: begin
                if (!neg_reg && rnd_m > 28'd32767) begin
                    res_val_reg <= 16'h7FFF;
                    res_sat_reg <= 1'b1;
                end else if (neg_reg && rnd_m > 28'd32768) begin
                    res_val_reg <= 16'h8000;
                    res_sat_reg <= 1'b1;
                end else begin
                    res_val_reg <= neg_reg ? 16'(-rnd_m[15:0]) : rnd_m[15:0];
                    res_sat_reg <= 1'b0;
                end
            end
            ST_C_START: begin
                idx_reg   <= '0;
                alpha_reg <= (sal_reg > ALPHA_ONE) ? ALPHA_ONE : sal_reg;
            end
            ST_C_ADIV: alpha_reg <= iter_res[ALPHA_W-1:0];
            ST_C_LOAD: begin
                om_reg <= mean_e;
                ov_reg <= var_e;
                bq_reg <= bsq_e;
                n1_reg <= bsum_e[BSUM_W-1];
            end
            ST_C_MBDIV: begin
                // batch mean in Q16.16, clamped; the sum's sign sits in n1_reg
                if (!n1_reg) begin
                    mb_reg <= mbq_big ? 32'sh7FFF_FFFF : $signed(mbq_pos);
                end else if (mbq_big && (|iter_res[ITER_NW-1:32] || |iter_res[30:0])) begin
                    mb_reg <= 32'sh8000_0000;
                end else begin
                    mb_reg <= $signed(-mbq_pos);
                end
            end
            ST_C_MEAN1: begin
                d1_reg <= 33'(mb_reg) - 33'(om_reg);
            end
            ST_C_MEAN2: begin
                p1_reg <= (d1_reg[32] ? 33'(-d1_reg) : 33'(d1_reg)) * alpha_reg;
                n1_reg <= d1_reg[32];
            end
            ST_C_MEAN3: begin
                if (mt > 37'sh0_7FFF_FFFF) begin
                    m_reg <= 32'sh7FFF_FFFF;
                end else if (mt < -37'sh0_8000_0000) begin
                    m_reg <= 32'sh8000_0000;
                end else begin
                    m_reg <= mt[31:0];
                end
            end
            ST_C_SQ1: mb2_reg <= 40'((mbsq + 64'h80_0000) >> 24);
            ST_C_SQ2: dd_reg  <= 42'((dsq + 66'h80_0000) >> 24);
            ST_C_T1WAIT: t1_reg <= iter_res[55:0];
            ST_C_VAR1: begin
                if (vt < 0) begin
                    vb_reg <= '0;
                end else if (vt > 59'(VAR_MAX)) begin
                    vb_reg <= VAR_MAX;
                end else begin
                    vb_reg <= vt[39:0];
                end
            end
            ST_C_VAR2: dv_reg <= 41'(vb_reg) - 41'(ov_reg);
            ST_C_VAR3: begin
                p2_reg <= dvmag * alpha_reg;
                n2_reg <= dv_reg[40];
            end
            ST_C_VAR4: begin
                if (vt2 < 0) begin
                    v_reg <= '0;
                end else if (vt2 > 44'(VAR_MAX)) begin
                    v_reg <= VAR_MAX;
                end else begin
                    v_reg <= vt2[39:0];
                end
            end
            ST_C_SQWAIT: begin
                if (!iter_busy) begin
                    idx_reg <= idx_reg + CC_W'(1);
                end
            end
            ST_C_DONE: res_cd_reg <= 1'b1;
            default: ;
        endcase
        if (st_reg == ST_OUT && out_free) begin
            m_tdata_reg <= res_val_reg;
            m_tuser_reg <= {res_cd_reg, res_sat_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

// ===== sv/rscn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the statistics and the batch sums.
`default_nettype none
module rscn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                        aclk,
    input  wire logic                                        wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/rscn_iter.sv =====
// Shared iterative unit: restoring division one quotient bit per cycle and
// integer square root one result bit per cycle. Depends on rscn_pkg.
`default_nettype none
module rscn_iter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rscn_pkg::iter_req_t           req,
    output logic                               busy,
    output logic [rscn_pkg::ITER_NW-1:0]       result
);
    import rscn_pkg::*;

    localparam logic [6:0] DIV_STEPS  = 7'(ITER_NW);
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    logic               busy_reg;
    logic [6:0]         cnt_reg;
    iter_op_t           op_reg;
    logic [ITER_NW-1:0] num_reg;
    logic [ITER_DW:0]   rem_reg;
    logic [ITER_DW-1:0] den_reg;
    logic [63:0]        x_reg;
    logic [63:0]        r_reg;
    logic [63:0]        bit_reg;

    logic [ITER_DW:0]   rem_sh;
    logic               div_ge;
    logic [63:0]        rb;
    logic               sq_ge;

    always_comb begin
        rem_sh = {rem_reg[ITER_DW-1:0], num_reg[ITER_NW-1]};
        div_ge = rem_sh >= {1'b0, den_reg};
        rb     = r_reg + bit_reg;
        sq_ge  = x_reg >= rb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (!busy_reg) begin
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == OP_DIV) ? DIV_STEPS - 7'd1 : SQRT_STEPS - 7'd1;
            end
        end else begin
            if (cnt_reg == 7'd0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg) begin
            if (req.start) begin
                op_reg  <= req.op;
                num_reg <= req.num;
                den_reg <= req.den;
                rem_reg <= '0;
                x_reg   <= req.num[63:0];
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
        end else if (op_reg == OP_DIV) begin
            rem_reg <= div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            num_reg <= {num_reg[ITER_NW-2:0], div_ge};
        end else begin
            if (sq_ge) begin
                x_reg <= x_reg - rb;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy   = busy_reg;
    assign result = (op_reg == OP_DIV) ? num_reg : {7'd0, r_reg};

endmodule
`default_nettype wire
